// File: sv/path_metric_evaluator_defines.svh
// assertion macros shared by the path metric evaluator modules
`ifndef PATH_METRIC_EVALUATOR_DEFINES_SVH
`define PATH_METRIC_EVALUATOR_DEFINES_SVH

`ifndef SYNTH
// clocked check, quiet while reset is held, with its own message
`define PME_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check with a generic message
`define PME_ASSERT(lbl, prop) \
  `PME_ASSERT_MSG(lbl, prop, "path metric evaluator check failed")
`else
`define PME_ASSERT_MSG(lbl, prop, msg)
`define PME_ASSERT(lbl, prop)
`endif

`endif

// File: sv/pme_pkg.sv
// shared types and constants of the path metric evaluator
`timescale 1ns / 1ps

package pme_pkg;

  localparam int MAX_NODES_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 6;
  localparam int ADDR_W   = 32;
  localparam int VALUE_W  = 32;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 1;

  // action codes on the input stream
  localparam logic [ACTION_W-1:0] ACT_NODE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EDGE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HOP  = 2'd2;

  // metric modes
  localparam logic MODE_LAT_SUM = 1'b0;
  localparam logic MODE_BW_MIN  = 1'b1;

  typedef enum logic [1:0] {
    CMD_NODE = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_HOP  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [INDEX_W-1:0]    node_index;
    logic [INDEX_W-1:0]    column_index;
    logic [ADDR_W-1:0]     address;
    logic [VALUE_W-1:0]    edge_value;
    logic                  metric_mode;
    logic                  last_hop;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// File: sv/pme_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module pme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/pme_front.sv
// front end: takes items, decodes and filters them, queues commands
`timescale 1ns / 1ps
`include "path_metric_evaluator_defines.svh"

module pme_front #(
  parameter int MAX_NODES = pme_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // node_index, column_index, address, edge_value, zero pad
  input  logic [pme_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action, metric_mode
  input  logic [pme_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                             in_tlast,
  output pme_pkg::queue_head_t             head_o,
  input  logic                             pop_i
);

  pme_pkg::cmd_t             q_r [2];
  logic                      wr_ptr_r, wr_ptr_nxt;
  logic                      rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                count_r, count_nxt;
  logic                      accept;
  logic                      keep;
  logic                      push;
  pme_pkg::cmd_t             cmd;
  logic [pme_pkg::ACTION_W-1:0] action;

  assign action = in_tuser[1:0];

  // field unpack
  always_comb begin
    cmd.kind         = pme_pkg::CMD_HOP;
    cmd.node_index   = in_tdata[5:0];
    cmd.column_index = in_tdata[11:6];
    cmd.address      = in_tdata[43:12];
    cmd.edge_value   = in_tdata[75:44];
    cmd.metric_mode  = in_tuser[2];
    cmd.last_hop     = in_tlast;
    keep             = 1'b0;
    case (action)
      pme_pkg::ACT_NODE: begin
        cmd.kind = pme_pkg::CMD_NODE;
        keep     = int'(cmd.node_index) < MAX_NODES;
      end
      pme_pkg::ACT_EDGE: begin
        cmd.kind = pme_pkg::CMD_EDGE;
        keep     = (int'(cmd.node_index) < MAX_NODES) && (int'(cmd.column_index) < MAX_NODES);
      end
      pme_pkg::ACT_HOP: begin
        cmd.kind = pme_pkg::CMD_HOP;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && keep;

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_i ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  assign head_o.valid = (count_r != 2'd0);
  assign head_o.cmd   = q_r[rd_ptr_r];

  `PME_ASSERT(a_queue_no_underflow, pop_i |-> (count_r != 2'd0))
  `PME_ASSERT(a_queue_bound, count_r != 2'd3)
  `PME_ASSERT_MSG(a_queue_fill, (push && !pop_i) |=> (count_r == $past(count_r) + 2'd1),
    "queue count did not follow a push")

endmodule

// File: sv/pme_back.sv
// back end: node table, edge matrix, hop matching and metric accumulation
`timescale 1ns / 1ps
`include "path_metric_evaluator_defines.svh"

module pme_back #(
  parameter int MAX_NODES = pme_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [pme_pkg::ADDR_W-1:0]       origin_i,
  input  pme_pkg::queue_head_t             head_i,
  output logic                             pop_o,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // path_metric
  output logic [pme_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // address_missing
  output logic [pme_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  localparam int NODE_SLOTS = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int MAT_DEPTH  = NODE_SLOTS * NODE_SLOTS;
  localparam int MAT_AW     = $clog2(MAT_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_READ  = 4'b0100,
    ST_ACC   = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  pme_pkg::cmd_t                 cmd_r;
  logic [pme_pkg::ADDR_W-1:0]    table_r [NODE_SLOTS];
  logic [NODE_SLOTS-1:0]         valid_r;
  logic [NODE_SLOTS-1:0]         hop_vec_r, org_vec_r;
  logic [SLOT_W-1:0]             to_idx_r;
  logic                          to_hit_r;
  logic                          edge_ok_r;
  logic [SLOT_W-1:0]             prev_r, prev_nxt;
  logic [pme_pkg::VALUE_W-1:0]   acc_r, acc_nxt;
  logic                          first_r, first_nxt;
  logic                          miss_r, miss_nxt;
  logic                          out_valid_r;
  logic [pme_pkg::VALUE_W-1:0]   out_metric_r;
  logic                          out_missing_r;

  logic                          pop_node, pop_edge, pop_hop;
  logic [SLOT_W-1:0]             hop_idx, org_idx, from_idx;
  logic                          hop_any, org_any, from_hit;
  logic                          acc_fire;
  logic                          out_free;
  logic [MAT_AW-1:0]             wr_addr, rd_addr;
  logic [pme_pkg::VALUE_W-1:0]   edge_val;
  logic [pme_pkg::VALUE_W:0]     sum;
  logic [pme_pkg::VALUE_W-1:0]   acc_upd;
  logic                          miss_upd;

  // dispatch from the queue head
  assign pop_o    = (state_r == ST_IDLE) && head_i.valid;
  assign pop_node = pop_o && (head_i.cmd.kind == pme_pkg::CMD_NODE);
  assign pop_edge = pop_o && (head_i.cmd.kind == pme_pkg::CMD_EDGE);
  assign pop_hop  = pop_o && (head_i.cmd.kind == pme_pkg::CMD_HOP);

  // node table
  always_ff @(posedge clk) begin
    if (pop_node) begin
      table_r[head_i.cmd.node_index[SLOT_W-1:0]] <= head_i.cmd.address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (pop_node) begin
      valid_r[head_i.cmd.node_index[SLOT_W-1:0]] <= 1'b1;
    end
  end

  // parallel match of hop and origin, registered
  always_ff @(posedge clk) begin
    if (state_r == ST_MATCH) begin
      for (int i = 0; i < NODE_SLOTS; i++) begin
        hop_vec_r[i] <= valid_r[i] && (table_r[i] == cmd_r.address);
        org_vec_r[i] <= valid_r[i] && (table_r[i] == origin_i);
      end
    end
  end

  // highest matching slot wins
  always_comb begin
    hop_idx = '0;
    org_idx = '0;
    for (int i = 0; i < NODE_SLOTS; i++) begin
      if (hop_vec_r[i]) begin
        hop_idx = SLOT_W'(i);
      end
      if (org_vec_r[i]) begin
        org_idx = SLOT_W'(i);
      end
    end
    hop_any  = |hop_vec_r;
    org_any  = |org_vec_r;
    from_idx = first_r ? org_idx : prev_r;
    from_hit = first_r ? org_any : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      to_idx_r  <= hop_idx;
      to_hit_r  <= hop_any;
      edge_ok_r <= from_hit && hop_any;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_hop) begin
      cmd_r <= head_i.cmd;
    end
  end

  // edge matrix
  assign wr_addr = MAT_AW'(int'(head_i.cmd.node_index[SLOT_W-1:0]) * NODE_SLOTS
                           + int'(head_i.cmd.column_index[SLOT_W-1:0]));
  assign rd_addr = MAT_AW'(int'(from_idx) * NODE_SLOTS + int'(hop_idx));

  pme_ram #(
    .WIDTH (pme_pkg::VALUE_W),
    .DEPTH (MAT_DEPTH)
  ) u_matrix (
    .clk     (clk),
    .wr_en   (pop_edge),
    .wr_addr (wr_addr),
    .wr_data (head_i.cmd.edge_value),
    .rd_en   (state_r == ST_READ),
    .rd_addr (rd_addr),
    .rd_data (edge_val)
  );

  // accumulate
  assign out_free = !out_valid_r || out_tready;
  assign acc_fire = (state_r == ST_ACC) && (!cmd_r.last_hop || out_free);

  always_comb begin
    sum      = {1'b0, acc_r} + {1'b0, edge_val};
    acc_upd  = acc_r;
    if (edge_ok_r) begin
      if (first_r) begin
        acc_upd = edge_val;
      end else if (cmd_r.metric_mode == pme_pkg::MODE_LAT_SUM) begin
        acc_upd = sum[pme_pkg::VALUE_W] ? '1 : sum[pme_pkg::VALUE_W-1:0];
      end else if (edge_val < acc_r) begin
        acc_upd = edge_val;
      end
    end
    miss_upd = miss_r || !edge_ok_r;
  end

  always_comb begin
    acc_nxt   = acc_r;
    miss_nxt  = miss_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    if (acc_fire) begin
      if (cmd_r.last_hop) begin
        acc_nxt   = '0;
        miss_nxt  = 1'b0;
        prev_nxt  = '0;
        first_nxt = 1'b1;
      end else begin
        acc_nxt   = acc_upd;
        miss_nxt  = miss_upd;
        prev_nxt  = to_hit_r ? to_idx_r : '0;
        first_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  state_nxt = pop_hop ? ST_MATCH : ST_IDLE;
      ST_MATCH: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = acc_fire ? ST_IDLE : ST_ACC;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      miss_r      <= 1'b0;
      prev_r      <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      miss_r  <= miss_nxt;
      prev_r  <= prev_nxt;
      first_r <= first_nxt;
      if (acc_fire && cmd_r.last_hop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire && cmd_r.last_hop) begin
      out_metric_r  <= miss_upd ? '0 : acc_upd;
      out_missing_r <= miss_upd;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_metric_r;
  assign out_tuser[0] = out_missing_r;

  `PME_ASSERT(a_pop_only_idle, pop_o |-> (state_r == ST_IDLE))
  `PME_ASSERT_MSG(a_miss_zero_metric, (out_valid_r && out_missing_r) |-> (out_metric_r == '0),
    "missing address result carries a nonzero metric")
  `PME_ASSERT_MSG(a_rearm_after_last, (acc_fire && cmd_r.last_hop) |=> (first_r && !miss_r),
    "path state not rearmed after final hop")

endmodule

// File: sv/path_metric_evaluator.sv
// top level of the path metric evaluator
`timescale 1ns / 1ps

// Path metric evaluator. Load node addresses (action 0) and edge values
// (action 1), then stream the hops of a path (action 2), the final one
// marked with tlast. Each hop address is matched against all valid node
// slots at once, the highest matching slot wins; the first edge starts at
// the node holding origin_address (the user must write it on the cfg port
// only while idle; not enforced by the block). Latency mode sums edges
// with saturation, bandwidth mode keeps the minimum; one result per path,
// metric 0 and the missing flag set if any address did not match. Items
// pass through a two entry command queue to the back end, where a node or
// matrix write is done at its pop; a hop passes queue pop, registered
// parallel match, priority pick plus edge matrix read, accumulate; the
// next command pops only when idle. The final hop also waits for the
// output register to be free. Unwritten matrix entries read back
// undefined. The node table is limited to 64 slots by the 6 bit index.

module path_metric_evaluator #(
  parameter int MAX_NODES = pme_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // origin_address write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pme_pkg::ADDR_W-1:0]       cfg_data,
  // item stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // node_index, column_index, address, edge_value, zero pad
  input  logic [pme_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action, metric_mode
  input  logic [pme_pkg::IN_TUSER_W-1:0]   in_tuser,
  // last_hop
  input  logic                             in_tlast,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // path_metric
  output logic [pme_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // address_missing
  output logic [pme_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  logic [pme_pkg::ADDR_W-1:0] origin_r;
  pme_pkg::queue_head_t       head;
  logic                       pop;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
    end else if (cfg_valid) begin
      origin_r <= cfg_data;
    end
  end

  // decode and queue
  pme_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .head_o    (head),
    .pop_i     (pop)
  );

  // table, matrix and metric
  pme_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .origin_i   (origin_r),
    .head_i     (head),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
